FILE: rtl/sqrt_one_plus_x_series_defines.svh
// Assertion macros for the sqrt(1+x) series block.
// Used by the port checker; no other dependencies.
`ifndef SQRT_ONE_PLUS_X_SERIES_DEFINES_SVH
`define SQRT_ONE_PLUS_X_SERIES_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SQOP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SQOP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/sqop_pkg.sv
// Shared constants, types and helper functions for the sqrt(1+x) series block.
// No dependencies; used by the datapath, controller, top level and checker.
`default_nettype none

package sqop_pkg;

	localparam int MAX_TERMS = 64;
	localparam int FRAC_BITS = 16;

	// fixed field widths
	localparam int X_W     = 18;
	localparam int OUT_W   = 18;
	localparam int TC_W    = 7;
	localparam int PIN_W   = 16;
	localparam int USED_W  = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam int TERM_W    = FRAC_BITS + 3;
	localparam int CNT_W     = $clog2(MAX_TERMS + 1);
	localparam int COEF_W    = CNT_W + 2;
	localparam int PROD1_W   = TERM_W + X_W;
	localparam int PROD2_W   = PROD1_W + COEF_W;
	// term update divides by 2i * 2^16 = i * 2^17
	localparam int DEN_SHIFT = 17;
	localparam int MAG_W     = PROD2_W - DEN_SHIFT;
	localparam int DIV_STEPS = (MAG_W + 1) / 2;
	localparam int DIV_W     = 2 * DIV_STEPS;
	localparam int DSTEP_W   = $clog2(DIV_STEPS);
	localparam int SUM_W     = TERM_W + $clog2(MAX_TERMS) + 1;
	localparam int PREC_W    = (FRAC_BITS > PIN_W) ? FRAC_BITS : PIN_W;
	localparam int PREC_UP   = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam int PREC_DN   = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
	localparam int DCMP_W    = ((TERM_W + 1) > PREC_W) ? TERM_W + 1 : PREC_W;
	localparam int CONV_W    = SUM_W + 17;
	localparam int CMP_W     = ((CNT_W > TC_W) ? CNT_W : TC_W) + 1;

	localparam logic [TERM_W-2:0] TERM_LIM = '1;
	localparam logic signed [TERM_W-1:0] TERM_ONE = {3'b001, {FRAC_BITS{1'b0}}};

	localparam logic [CFG_IDX_W-1:0] REG_STOP_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TERM_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRECISION  = 2'd2;

	localparam logic MODE_PRECISION = 1'b0;
	localparam logic MODE_COUNT     = 1'b1;

	localparam logic [TC_W-1:0]  TC_RESET   = 7'd1;
	localparam logic [PIN_W-1:0] PREC_RESET = 16'd66;

	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic div_init;
		logic div_step;
		logic acc;
		logic cap_set;
	} dp_cmd_t;

	typedef struct packed {
		logic             diff_ok;
		logic [CNT_W-1:0] used;
	} dp_stat_t;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_MUL1  = 8'b0000_0010,
		S_MUL2  = 8'b0000_0100,
		S_DIVI  = 8'b0000_1000,
		S_DIV   = 8'b0001_0000,
		S_ACC   = 8'b0010_0000,
		S_CHECK = 8'b0100_0000,
		S_FIN   = 8'b1000_0000
	} state_t;

	// bring the Q0.16 precision register to the internal fraction scale
	function automatic logic [PREC_W-1:0] prec_scale(input logic [PIN_W-1:0] p);
		logic [PREC_W-1:0] r;
		r = PREC_W'(p);
		r = r << PREC_UP;
		r = r >> PREC_DN;
		return r;
	endfunction

	// bring the sum to Q2.16 (truncate toward zero) and saturate
	function automatic logic signed [OUT_W-1:0] to_q16(input logic signed [SUM_W-1:0] s);
		logic signed [CONV_W-1:0] v;
		logic signed [CONV_W-1:0] bias;
		v = CONV_W'(s);
		bias = '0;
		if (v[CONV_W-1])
			bias = CONV_W'((64'sd1 <<< PREC_UP) - 64'sd1);
		v = (v + bias) >>> PREC_UP;
		v = v <<< PREC_DN;
		if (v > CONV_W'(131071))
			v = CONV_W'(131071);
		else if (v < CONV_W'(-131072))
			v = CONV_W'(-131072);
		return OUT_W'(v);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/sqop_datapath.sv
// Datapath of the sqrt(1+x) series block: term registers, two multiply stages,
// radix-4 restoring divider by the term index, accumulator. Uses sqop_pkg.
`default_nettype none

module sqop_datapath (
	input  wire logic                                clk,
	input  wire sqop_pkg::dp_cmd_t                   cmd,
	input  wire logic signed [sqop_pkg::X_W-1:0]     x_value,
	input  wire logic [sqop_pkg::PIN_W-1:0]          precision,
	output sqop_pkg::dp_stat_t                       stat,
	output logic signed [sqop_pkg::OUT_W-1:0]        sum_out,
	output logic                                     cap_out
);

	logic signed [sqop_pkg::X_W-1:0]     x_q;
	logic signed [sqop_pkg::TERM_W-1:0]  cur_q;
	logic signed [sqop_pkg::TERM_W-1:0]  prev_q;
	logic signed [sqop_pkg::SUM_W-1:0]   sum_q;
	logic [sqop_pkg::CNT_W-1:0]          i_q;
	logic signed [sqop_pkg::PROD1_W-1:0] prod1_q;
	logic signed [sqop_pkg::PROD2_W-1:0] prod2_q;
	logic [sqop_pkg::DIV_W-1:0]          dvd_q;
	logic [sqop_pkg::CNT_W-1:0]          rem_q;
	logic                                sign_q;
	logic                                cap_q;

	logic signed [sqop_pkg::COEF_W-1:0]  coef;
	logic [sqop_pkg::PROD2_W-1:0]        mag_abs;
	logic [sqop_pkg::CNT_W:0]            trial;
	logic [sqop_pkg::CNT_W-1:0]          rem_n;
	logic [sqop_pkg::DIV_W-1:0]          dvd_n;
	logic [sqop_pkg::TERM_W-2:0]         q_mag;
	logic signed [sqop_pkg::TERM_W-1:0]  t_next;
	logic signed [sqop_pkg::TERM_W:0]    diff;
	logic [sqop_pkg::TERM_W:0]           diff_abs;
	logic                                diff_ok;

	// (3 - 2i)
	assign coef = sqop_pkg::COEF_W'(3) - {1'b0, i_q, 1'b0};

	assign mag_abs = prod2_q[sqop_pkg::PROD2_W-1] ?
		(~prod2_q + sqop_pkg::PROD2_W'(1)) : prod2_q;

	// two restoring steps per cycle; quotient bits shift in at the bottom
	always_comb begin
		rem_n = rem_q;
		dvd_n = dvd_q;
		trial = '0;
		for (int k = 0; k < 2; k++) begin
			trial = {rem_n, dvd_n[sqop_pkg::DIV_W-1]};
			dvd_n = {dvd_n[sqop_pkg::DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, i_q}) begin
				trial = trial - {1'b0, i_q};
				dvd_n[0] = 1'b1;
			end
			rem_n = trial[sqop_pkg::CNT_W-1:0];
		end
	end

	// clamp quotient magnitude, then restore sign
	assign q_mag = (|dvd_q[sqop_pkg::DIV_W-1:sqop_pkg::TERM_W-1]) ?
		sqop_pkg::TERM_LIM : dvd_q[sqop_pkg::TERM_W-2:0];
	assign t_next = sign_q ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

	assign diff = (sqop_pkg::TERM_W+1)'(cur_q) - (sqop_pkg::TERM_W+1)'(prev_q);
	assign diff_abs = diff[sqop_pkg::TERM_W] ? (~diff + 1'b1) : diff;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q   <= x_value;
			cur_q <= sqop_pkg::TERM_ONE;
			sum_q <= sqop_pkg::SUM_W'(sqop_pkg::TERM_ONE);
			i_q   <= sqop_pkg::CNT_W'(1);
			cap_q <= 1'b0;
		end
		if (cmd.mul1)
			prod1_q <= cur_q * x_q;
		if (cmd.mul2)
			prod2_q <= prod1_q * coef;
		if (cmd.div_init) begin
			sign_q <= prod2_q[sqop_pkg::PROD2_W-1];
			dvd_q  <= sqop_pkg::DIV_W'(mag_abs[sqop_pkg::PROD2_W-1:sqop_pkg::DEN_SHIFT]);
			rem_q  <= '0;
		end
		if (cmd.div_step) begin
			dvd_q <= dvd_n;
			rem_q <= rem_n;
		end
		if (cmd.acc) begin
			prev_q <= cur_q;
			cur_q  <= t_next;
			sum_q  <= sum_q + sqop_pkg::SUM_W'(t_next);
			i_q    <= i_q + sqop_pkg::CNT_W'(1);
		end
		if (cmd.cap_set)
			cap_q <= 1'b1;
	end

	assign diff_ok = sqop_pkg::DCMP_W'(diff_abs) <=
		sqop_pkg::DCMP_W'(sqop_pkg::prec_scale(precision));
	assign stat      = '{diff_ok: diff_ok, used: i_q};
	assign sum_out   = sqop_pkg::to_q16(sum_q);
	assign cap_out   = cap_q;

endmodule

`default_nettype wire

FILE: rtl/sqop_ctrl.sv
// Controller of the sqrt(1+x) series block: one-hot sequencer over the
// multiply, divide and accumulate steps, and the stop decision. Uses sqop_pkg.
`default_nettype none

module sqop_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          stop_mode,
	input  wire logic [sqop_pkg::TC_W-1:0]     term_count,
	input  wire logic                          out_free,
	input  wire sqop_pkg::dp_stat_t            stat,
	output sqop_pkg::dp_cmd_t                  cmd,
	output logic                               result_load
);

	sqop_pkg::state_t state_q, state_n;
	logic [sqop_pkg::DSTEP_W-1:0] step_q;
	logic [sqop_pkg::CMP_W-1:0]   tc_w, lim, used_w;
	logic                         count_done;

	assign tc_w = sqop_pkg::CMP_W'(term_count);
	assign lim  = (tc_w == '0) ? sqop_pkg::CMP_W'(1) :
		(tc_w > sqop_pkg::CMP_W'(sqop_pkg::MAX_TERMS)) ?
		sqop_pkg::CMP_W'(sqop_pkg::MAX_TERMS) : tc_w;
	assign used_w     = sqop_pkg::CMP_W'(stat.used);
	assign count_done = used_w >= lim;

	always_comb begin
		state_n     = state_q;
		cmd         = '0;
		in_ready    = 1'b0;
		result_load = 1'b0;
		case (state_q)
			sqop_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (stop_mode == sqop_pkg::MODE_COUNT && lim <= sqop_pkg::CMP_W'(1))
						state_n = sqop_pkg::S_FIN;
					else
						state_n = sqop_pkg::S_MUL1;
				end
			end
			sqop_pkg::S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_n  = sqop_pkg::S_MUL2;
			end
			sqop_pkg::S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_n  = sqop_pkg::S_DIVI;
			end
			sqop_pkg::S_DIVI: begin
				cmd.div_init = 1'b1;
				state_n      = sqop_pkg::S_DIV;
			end
			sqop_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == sqop_pkg::DSTEP_W'(sqop_pkg::DIV_STEPS - 1))
					state_n = sqop_pkg::S_ACC;
			end
			sqop_pkg::S_ACC: begin
				cmd.acc = 1'b1;
				state_n = sqop_pkg::S_CHECK;
			end
			sqop_pkg::S_CHECK: begin
				if (stop_mode == sqop_pkg::MODE_COUNT) begin
					state_n = count_done ? sqop_pkg::S_FIN : sqop_pkg::S_MUL1;
				end else if (stat.diff_ok) begin
					state_n = sqop_pkg::S_FIN;
				end else if (used_w >= sqop_pkg::CMP_W'(sqop_pkg::MAX_TERMS)) begin
					cmd.cap_set = 1'b1;
					state_n     = sqop_pkg::S_FIN;
				end else begin
					state_n = sqop_pkg::S_MUL1;
				end
			end
			sqop_pkg::S_FIN: begin
				// hold until the output register can take the result
				if (out_free) begin
					result_load = 1'b1;
					state_n     = sqop_pkg::S_IDLE;
				end
			end
			default: begin
				state_n = sqop_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sqop_pkg::S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_n;
			if (cmd.div_init)
				step_q <= '0;
			else if (cmd.div_step)
				step_q <= step_q + sqop_pkg::DSTEP_W'(1);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sqrt_one_plus_x_series.sv
// Each term after the first runs through the multiply steps, a divide setup, the divide
// steps at two quotient bits each, an accumulate and a stop check. Only one request is
// in flight; the next is taken once the result sits in the output register.
// Async reset idles the controller, clears out_valid and loads the register defaults.
// Top level: config registers, output register, controller and datapath.
// Depends on sqop_pkg, sqop_ctrl, sqop_datapath.
`default_nettype none

module sqrt_one_plus_x_series (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [sqop_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [sqop_pkg::CFG_DAT_W-1:0]        cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic signed [sqop_pkg::X_W-1:0]       x_value,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [sqop_pkg::OUT_W-1:0]          sum_value,
	output logic [sqop_pkg::USED_W-1:0]                terms_used,
	output logic                                       cap_reached
);

	logic                           stop_mode_q;
	logic [sqop_pkg::TC_W-1:0]      term_count_q;
	logic [sqop_pkg::PIN_W-1:0]     precision_q;

	logic                                out_valid_q;
	logic signed [sqop_pkg::OUT_W-1:0]   sum_q;
	logic [sqop_pkg::USED_W-1:0]         used_q;
	logic                                cap_q;

	sqop_pkg::dp_cmd_t              cmd;
	sqop_pkg::dp_stat_t             stat;
	logic signed [sqop_pkg::OUT_W-1:0] dp_sum;
	logic                           dp_cap;
	logic                           out_free;
	logic                           result_load;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_mode_q  <= sqop_pkg::MODE_PRECISION;
			term_count_q <= sqop_pkg::TC_RESET;
			precision_q  <= sqop_pkg::PREC_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				sqop_pkg::REG_STOP_MODE:  stop_mode_q  <= cfg_data[0];
				sqop_pkg::REG_TERM_COUNT: term_count_q <= cfg_data[sqop_pkg::TC_W-1:0];
				sqop_pkg::REG_PRECISION:  precision_q  <= cfg_data[sqop_pkg::PIN_W-1:0];
				default: begin
					// drop writes to unknown registers
				end
			endcase
		end
	end

	assign out_free = !out_valid_q || out_ready;

	sqop_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.stop_mode   (stop_mode_q),
		.term_count  (term_count_q),
		.out_free    (out_free),
		.stat        (stat),
		.cmd         (cmd),
		.result_load (result_load)
	);

	sqop_datapath u_dp (
		.clk       (clk),
		.cmd       (cmd),
		.x_value   (x_value),
		.precision (precision_q),
		.stat      (stat),
		.sum_out   (dp_sum),
		.cap_out   (dp_cap)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			sum_q  <= dp_sum;
			used_q <= sqop_pkg::USED_W'(stat.used);
			cap_q  <= dp_cap;
		end
	end

	assign out_valid   = out_valid_q;
	assign sum_value   = sum_q;
	assign terms_used  = used_q;
	assign cap_reached = cap_q;

endmodule

`default_nettype wire

FILE: rtl/sqop_checker.sv
// Port-level checker for sqrt_one_plus_x_series, bound to the top level.
// Depends on sqop_pkg and sqrt_one_plus_x_series_defines.svh.
`default_nettype none
`include "sqrt_one_plus_x_series_defines.svh"

module sqop_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_ready,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic signed [sqop_pkg::OUT_W-1:0] sum_value,
	input wire logic [sqop_pkg::USED_W-1:0]       terms_used,
	input wire logic                              cap_reached
);

	`SQOP_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "request accepted but block still ready")
	`SQOP_ASSERT_SAME(a_terms_nonzero, clk, arst_n, out_valid, terms_used != 7'd0, "result reports zero terms")
	`SQOP_ASSERT_SAME(a_cap_at_max, clk, arst_n, out_valid && cap_reached, terms_used == 7'(sqop_pkg::MAX_TERMS), "cap flag without full term count")
	`SQOP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(sum_value) && $stable(terms_used) && $stable(cap_reached), "stalled result changed")

endmodule

bind sqrt_one_plus_x_series sqop_checker u_sqop_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_sqrt_one_plus_x_series.sv
`timescale 1ns / 1ps
// Self-checking testbench for sqrt_one_plus_x_series, the binomial series for sqrt(1+x).
// Depends on sqop_pkg and the block; holds its own series evaluator to score the results not given in the plan.

module tb_sqrt_one_plus_x_series;

	localparam logic [sqop_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int IDLE_PCT     = 14;
	localparam int STALL_LIMIT  = 20000;
	localparam int DRAIN_CYCLES = 1300;
	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 33;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		logic signed [sqop_pkg::OUT_W-1:0] sum;
		logic [sqop_pkg::USED_W-1:0]       used;
		logic                              cap;
	} series_out_t;

	typedef struct {
		bit                                is_cfg;
		logic [sqop_pkg::CFG_IDX_W-1:0]    idx;
		logic [sqop_pkg::CFG_DAT_W-1:0]    data;
		logic signed [sqop_pkg::X_W-1:0]   x;
		bit                                known;
		series_out_t                       want;
	} plan_row_t;

	logic                              clk = 1'b0;
	logic                              arst_n;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic [sqop_pkg::CFG_IDX_W-1:0]    cfg_index;
	logic [sqop_pkg::CFG_DAT_W-1:0]    cfg_data;
	logic                              in_valid;
	logic                              in_ready;
	logic signed [sqop_pkg::X_W-1:0]   x_value;
	logic                              out_valid;
	logic                              out_ready;
	logic signed [sqop_pkg::OUT_W-1:0] sum_value;
	logic [sqop_pkg::USED_W-1:0]       terms_used;
	logic                              cap_reached;

	// shadow copy of the configuration registers
	logic                       mode_r;
	logic [sqop_pkg::TC_W-1:0]  count_r;
	logic [sqop_pkg::PIN_W-1:0] prec_r;

	series_out_t expected_sums[$];
	int          miss_count = 0;
	int          idle_cycles = 0;
	bit          calm = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	sqrt_one_plus_x_series dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.x_value     (x_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sum_value   (sum_value),
		.terms_used  (terms_used),
		.cap_reached (cap_reached)
	);

	// term * (3 - 2i) * x / (2i * 2^16), truncated toward zero, then clamped
	function automatic longint next_series_term(longint term, longint i, longint x);
		longint t;
		longint lim;
		lim = (64'sd1 <<< (sqop_pkg::FRAC_BITS + 2)) - 1;
		t = (term * (3 - 2 * i) * x) / ((2 * i) * 65536);
		if (t > lim)
			t = lim;
		if (t < -lim)
			t = -lim;
		return t;
	endfunction

	function automatic series_out_t series_sum(logic signed [sqop_pkg::X_W-1:0] x);
		series_out_t r;
		longint xv, cur, prev, acc, n, lim, diff, thr;
		bit capped;
		xv = x;
		cur = 64'sd1 <<< sqop_pkg::FRAC_BITS;
		acc = cur;
		n = 1;
		capped = 1'b0;
		if (mode_r == sqop_pkg::MODE_COUNT) begin
			lim = longint'(count_r);
			if (lim < 1)
				lim = 1;
			if (lim > sqop_pkg::MAX_TERMS)
				lim = sqop_pkg::MAX_TERMS;
			while (n < lim) begin
				cur = next_series_term(cur, n, xv);
				acc += cur;
				n++;
			end
		end else begin
			thr = longint'(prec_r);
			if (sqop_pkg::FRAC_BITS >= 16)
				thr = thr <<< (sqop_pkg::FRAC_BITS - 16);
			else
				thr = thr >>> (16 - sqop_pkg::FRAC_BITS);
			forever begin
				prev = cur;
				cur = next_series_term(cur, n, xv);
				acc += cur;
				n++;
				diff = (cur > prev) ? cur - prev : prev - cur;
				if (diff <= thr)
					break;
				if (n >= sqop_pkg::MAX_TERMS) begin
					capped = 1'b1;
					break;
				end
			end
		end
		if (sqop_pkg::FRAC_BITS >= 16)
			acc = acc / (64'sd1 <<< (sqop_pkg::FRAC_BITS - 16));
		else
			acc = acc * (64'sd1 <<< (16 - sqop_pkg::FRAC_BITS));
		if (acc > 131071)
			acc = 131071;
		if (acc < -131072)
			acc = -131072;
		r.sum = acc[sqop_pkg::OUT_W-1:0];
		r.used = n[sqop_pkg::USED_W-1:0];
		r.cap = capped;
		return r;
	endfunction

	function automatic bit roll_idle();
		return !calm && ($urandom_range(99) < IDLE_PCT);
	endfunction

	function automatic plan_row_t reg_row(logic [sqop_pkg::CFG_IDX_W-1:0] idx,
			logic [sqop_pkg::CFG_DAT_W-1:0] data);
		plan_row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	function automatic plan_row_t arg_row(logic signed [sqop_pkg::X_W-1:0] x);
		plan_row_t r;
		r = '{default: '0};
		r.x = x;
		return r;
	endfunction

	function automatic plan_row_t known_row(logic signed [sqop_pkg::X_W-1:0] x,
			logic signed [sqop_pkg::OUT_W-1:0] sum, logic [sqop_pkg::USED_W-1:0] used,
			logic cap);
		plan_row_t r;
		r = arg_row(x);
		r.known = 1'b1;
		r.want = '{sum: sum, used: used, cap: cap};
		return r;
	endfunction

	task automatic put_x(input logic signed [sqop_pkg::X_W-1:0] x, input bit known,
			input series_out_t want);
		cfg_valid <= 1'b0;
		if (roll_idle()) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while (roll_idle())
				@(posedge clk);
		end
		in_valid <= 1'b1;
		x_value <= x;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_sums.push_back(known ? want : series_sum(x));
	endtask

	task automatic set_reg(input logic [sqop_pkg::CFG_IDX_W-1:0] idx,
			input logic [sqop_pkg::CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			sqop_pkg::REG_STOP_MODE:  mode_r = data[0];
			sqop_pkg::REG_TERM_COUNT: count_r = data[sqop_pkg::TC_W-1:0];
			sqop_pkg::REG_PRECISION:  prec_r = data[sqop_pkg::PIN_W-1:0];
			default: ;
		endcase
	endtask

	// hold requests until every pending result has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_sums.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk)
		out_ready <= !roll_idle();

	always @(posedge clk) begin : check_results
		series_out_t head;
		if (arst_n && out_valid && out_ready) begin
			if (expected_sums.size() == 0) begin
				if (miss_count < REPORT_MAX)
					$display("unexpected result: sum %0d terms %0d cap %0b",
						sum_value, terms_used, cap_reached);
				miss_count++;
			end else begin
				head = expected_sums.pop_front();
				if (sum_value !== head.sum || terms_used !== head.used
						|| cap_reached !== head.cap) begin
					if (miss_count < REPORT_MAX)
						$display({"mismatch: expected sum %0d terms %0d cap %0b,",
							" got sum %0d terms %0d cap %0b"},
							head.sum, head.used, head.cap,
							sum_value, terms_used, cap_reached);
					miss_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL sqrt_one_plus_x_series");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		plan_row_t                       plan[$];
		plan_row_t                       row;
		series_out_t                     none;
		logic [sqop_pkg::CFG_DAT_W-1:0]  word;
		logic signed [sqop_pkg::X_W-1:0] xr;
		int                              pick;

		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		x_value = '0;
		out_ready = 1'b0;
		mode_r = sqop_pkg::MODE_PRECISION;
		count_r = sqop_pkg::TC_RESET;
		prec_r = sqop_pkg::PREC_RESET;
		none = '0;

		// reset defaults first, then count mode edges, then precision mode edges
		plan.push_back(known_row(18'sd0, 18'sd65536, 7'd3, 1'b0));
		plan.push_back(arg_row(18'sd65536));
		plan.push_back(arg_row(-18'sd65536));
		plan.push_back(reg_row(sqop_pkg::REG_STOP_MODE, {15'd0, sqop_pkg::MODE_COUNT}));
		plan.push_back(known_row(18'sd65536, 18'sd65536, 7'd1, 1'b0));
		plan.push_back(known_row(18'sh20000, 18'sd65536, 7'd1, 1'b0));
		plan.push_back(reg_row(sqop_pkg::REG_TERM_COUNT, 16'd0));
		plan.push_back(known_row(18'sd12345, 18'sd65536, 7'd1, 1'b0));
		plan.push_back(reg_row(sqop_pkg::REG_TERM_COUNT, 16'd2));
		plan.push_back(known_row(18'sd65536, 18'sd98304, 7'd2, 1'b0));
		plan.push_back(known_row(-18'sd65536, 18'sd32768, 7'd2, 1'b0));
		plan.push_back(known_row(18'sh20000, 18'sd0, 7'd2, 1'b0));
		plan.push_back(known_row(18'sd131071, 18'sd131071, 7'd2, 1'b0));
		plan.push_back(reg_row(sqop_pkg::REG_TERM_COUNT, 16'd64));
		plan.push_back(arg_row(18'sd65536));
		plan.push_back(arg_row(-18'sd65536));
		plan.push_back(arg_row(18'sh20000));
		plan.push_back(reg_row(sqop_pkg::REG_TERM_COUNT, 16'hFFFF));
		plan.push_back(arg_row(18'sd40000));
		plan.push_back(reg_row(REG_UNUSED, 16'h0003));
		plan.push_back(arg_row(-18'sd40000));
		plan.push_back(reg_row(sqop_pkg::REG_STOP_MODE,
			{15'd0, sqop_pkg::MODE_PRECISION}));
		plan.push_back(reg_row(sqop_pkg::REG_PRECISION, 16'd0));
		plan.push_back(arg_row(18'sd65536));
		plan.push_back(arg_row(-18'sd65536));
		plan.push_back(arg_row(18'sd131071));
		plan.push_back(reg_row(sqop_pkg::REG_PRECISION, 16'hFFFF));
		plan.push_back(known_row(18'sd65536, 18'sd98304, 7'd2, 1'b0));
		plan.push_back(arg_row(18'sd1));
		plan.push_back(arg_row(-18'sd1));

		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[k]) begin
			row = plan[k];
			if (row.is_cfg) begin
				drain();
				set_reg(row.idx, row.data);
			end else begin
				put_x(row.x, row.known, row.want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			calm = (ph == 5);
			word = sqop_pkg::CFG_DAT_W'($urandom);
			word[0] = (ph % 2 == 1) ? sqop_pkg::MODE_COUNT : sqop_pkg::MODE_PRECISION;
			set_reg(sqop_pkg::REG_STOP_MODE, word);
			word = sqop_pkg::CFG_DAT_W'($urandom);
			case ($urandom_range(7))
				0: word[sqop_pkg::TC_W-1:0] = 7'd0;
				1: word[sqop_pkg::TC_W-1:0] = 7'd1;
				2: word[sqop_pkg::TC_W-1:0] = 7'd64;
				3: word[sqop_pkg::TC_W-1:0] = sqop_pkg::TC_W'($urandom_range(65, 127));
				4: word[sqop_pkg::TC_W-1:0] = sqop_pkg::TC_W'($urandom_range(33, 63));
				default: word[sqop_pkg::TC_W-1:0] = sqop_pkg::TC_W'($urandom_range(2, 16));
			endcase
			set_reg(sqop_pkg::REG_TERM_COUNT, word);
			case ($urandom_range(4))
				0: word = 16'd0;
				1: word = 16'hFFFF;
				2: word = sqop_pkg::CFG_DAT_W'($urandom_range(15));
				3: word = sqop_pkg::CFG_DAT_W'($urandom_range(16, 300));
				default: word = sqop_pkg::CFG_DAT_W'($urandom);
			endcase
			set_reg(sqop_pkg::REG_PRECISION, word);
			if ($urandom_range(3) == 0)
				set_reg(REG_UNUSED, sqop_pkg::CFG_DAT_W'($urandom));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(99);
				if (pick < 10) begin
					xr = sqop_pkg::X_W'($urandom);
				end else if (pick < 20) begin
					case ($urandom_range(3))
						0: xr = 18'sd65536;
						1: xr = -18'sd65536;
						2: xr = 18'sd0;
						default: xr = sqop_pkg::X_W'(int'($urandom_range(16)) - 65536);
					endcase
				end else begin
					xr = sqop_pkg::X_W'(int'($urandom_range(131072)) - 65536);
				end
				put_x(xr, 1'b0, none);
				// let the pipe run dry mid-phase now and then
				if (n == PHASE_ITEMS / 2 && ph % 3 == 0)
					drain();
			end
		end

		drain();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (miss_count == 0)
			$display("PASS sqrt_one_plus_x_series");
		else
			$display("FAIL sqrt_one_plus_x_series");
		$finish;
	end

endmodule

FILE: sqrt_one_plus_x_series.f
+incdir+rtl
rtl/sqop_pkg.sv
rtl/sqop_datapath.sv
rtl/sqop_ctrl.sv
rtl/sqrt_one_plus_x_series.sv
rtl/sqop_checker.sv
tb/sv/tb_sqrt_one_plus_x_series.sv
